@@ rtl/core/bbpa_pkg.sv @@
// bbpa_pkg: shared sizes, codes and request/result types for the block pool allocator
// no dependencies; used by every module in rtl/core
`default_nettype none

package bbpa_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int ROW_W      = 8;
  localparam int ROWS       = MAX_BLOCKS / ROW_W;
  localparam int RA_W       = $clog2(ROWS);
  localparam int BIT_W      = $clog2(ROW_W);
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int SPAN_W     = CNT_W + 16;
  localparam int PROD_W     = IDX_W + 16;
  localparam int STEP_W     = $clog2(IDX_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT  = 2'd2;

  localparam logic [31:0] BASE_ADDRESS_RESET = 32'h2000_0000;
  localparam logic [15:0] BLOCK_SIZE_RESET   = 16'd64;
  localparam logic [8:0]  BLOCK_COUNT_RESET  = 9'd256;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TOO_LARGE    = 3'd1,
    ST_EMPTY        = 3'd2,
    ST_OUT_OF_RANGE = 3'd3,
    ST_NULL_ADDRESS = 3'd4
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] request_length;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] block_address;
    logic [7:0]  block_number;
  } rsp_t;

  typedef struct packed {
    logic             en;
    logic [RA_W-1:0]  addr;
    logic [ROW_W-1:0] data;
  } map_wr_t;

endpackage

`default_nettype wire

@@ rtl/core/bitmap_block_pool_allocator_unit.sv @@
// Fixed-size block pool allocator: configuration registers, sequencer, result register.
// An allocate request scans the free bitmap memory one row of eight blocks per cycle; one
// that finds a free block then multiplies its index by the block size and adds the base
// address, and one that finds none reports an empty pool. A free request that lies inside
// the pool divides its offset by the block size in a divider that yields one bit of the
// block index per cycle, then reads and rewrites the bitmap row. Requests refused as
// too_large, empty pool or null_address go straight to the result; out_of_range frees do
// so after the range check. After reset the bitmap memory is swept to all free, one row
// per cycle, and no request is taken until then; configuration writes are taken at any time.
// One request is worked on at a time, and the next is taken while a finished result still
// waits in the output register.
`default_nettype none

module bitmap_block_pool_allocator_unit (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_write,
  input  wire  [bbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [bbpa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire bbpa_pkg::req_t             in_data,
  output logic                            out_valid,
  input  wire                             out_ready,
  output bbpa_pkg::rsp_t                  out_data
);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_ASCAN = 10'b00_0000_0100,
    S_AMUL  = 10'b00_0000_1000,
    S_AADD  = 10'b00_0001_0000,
    S_FCHK  = 10'b00_0010_0000,
    S_FDIV  = 10'b00_0100_0000,
    S_FRD   = 10'b00_1000_0000,
    S_FWR   = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state;

  logic [31:0] base_address;
  logic [15:0] block_size;
  logic [8:0]  block_count;

  logic [bbpa_pkg::CNT_W-1:0]  n_use;
  logic [bbpa_pkg::RA_W-1:0]   clr_row;
  logic [bbpa_pkg::RA_W:0]     scan_row;
  logic [bbpa_pkg::RA_W-1:0]   chk_row;
  logic                        chk_vld;
  logic [bbpa_pkg::IDX_W-1:0]  idx;
  logic [bbpa_pkg::PROD_W-1:0] prod;
  logic [31:0]                 off;
  logic                        below;
  logic [bbpa_pkg::SPAN_W-1:0] span;
  bbpa_pkg::rsp_t              res;

  logic                        in_fire;
  logic                        issue_ok;
  logic                        out_of_pool;
  logic [bbpa_pkg::ROW_W-1:0]  masked;
  logic                        hit;
  logic [bbpa_pkg::BIT_W-1:0]  hit_bit;

  bbpa_pkg::map_wr_t           map_wr;
  logic                        ram_re;
  logic [bbpa_pkg::RA_W-1:0]   ram_raddr;
  logic [bbpa_pkg::ROW_W-1:0]  ram_rdata;

  logic                        div_start;
  logic                        div_done;
  logic [bbpa_pkg::IDX_W-1:0]  div_q;

  bbpa_map_ram u_map (
    .clk   (clk),
    .wr    (map_wr),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bbpa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (off),
    .divisor  (block_size),
    .done     (div_done),
    .quotient (div_q)
  );

  assign n_use = (32'(block_count) > 32'(bbpa_pkg::MAX_BLOCKS))
               ? bbpa_pkg::CNT_W'(bbpa_pkg::MAX_BLOCKS)
               : bbpa_pkg::CNT_W'(block_count);

  assign in_ready    = (state == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign issue_ok    = {scan_row, bbpa_pkg::BIT_W'(0)} < n_use;
  assign out_of_pool = below || (32'(span) <= off);
  assign div_start   = (state == S_FCHK) && !out_of_pool;

  // free bits of the row under check that lie inside the pool
  always_comb begin
    for (int b = 0; b < bbpa_pkg::ROW_W; b++) begin
      masked[b] = chk_vld && ram_rdata[b]
               && ({1'b0, chk_row, bbpa_pkg::BIT_W'(b)} < n_use);
    end
  end

  assign hit = |masked;

  always_comb begin
    hit_bit = '0;
    for (int b = bbpa_pkg::ROW_W - 1; b >= 0; b--) begin
      if (masked[b]) begin
        hit_bit = bbpa_pkg::BIT_W'(b);
      end
    end
  end

  always_comb begin
    map_wr    = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (state == S_CLEAR) begin
      map_wr.en   = 1'b1;
      map_wr.addr = clr_row;
      map_wr.data = '1;
    end else if (state == S_ASCAN) begin
      ram_re    = issue_ok;
      ram_raddr = scan_row[bbpa_pkg::RA_W-1:0];
      if (hit) begin
        map_wr.en   = 1'b1;
        map_wr.addr = chk_row;
        map_wr.data = ram_rdata & ~(bbpa_pkg::ROW_W'(1) << hit_bit);
      end
    end else if (state == S_FRD) begin
      ram_re    = 1'b1;
      ram_raddr = idx[bbpa_pkg::IDX_W-1:bbpa_pkg::BIT_W];
    end else if (state == S_FWR) begin
      map_wr.en   = 1'b1;
      map_wr.addr = idx[bbpa_pkg::IDX_W-1:bbpa_pkg::BIT_W];
      map_wr.data = ram_rdata | (bbpa_pkg::ROW_W'(1) << idx[bbpa_pkg::BIT_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= bbpa_pkg::BASE_ADDRESS_RESET;
      block_size   <= bbpa_pkg::BLOCK_SIZE_RESET;
      block_count  <= bbpa_pkg::BLOCK_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bbpa_pkg::REG_BASE_ADDRESS: base_address <= cfg_data;
        bbpa_pkg::REG_BLOCK_SIZE:   block_size   <= cfg_data[15:0];
        bbpa_pkg::REG_BLOCK_COUNT:  block_count  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_row <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == bbpa_pkg::RA_W'(bbpa_pkg::ROWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            res.block_address <= '0;
            res.block_number  <= '0;
            if (in_data.kind == bbpa_pkg::KIND_ALLOC) begin
              scan_row <= '0;
              chk_vld  <= 1'b0;
              if (in_data.request_length > block_size) begin
                res.status <= bbpa_pkg::ST_TOO_LARGE;
                state      <= S_DONE;
              end else if (n_use == '0) begin
                res.status <= bbpa_pkg::ST_EMPTY;
                state      <= S_DONE;
              end else begin
                state <= S_ASCAN;
              end
            end else begin
              off   <= in_data.free_address - base_address;
              below <= in_data.free_address < base_address;
              span  <= bbpa_pkg::SPAN_W'(n_use) * bbpa_pkg::SPAN_W'(block_size);
              if (in_data.free_address == '0) begin
                res.status <= bbpa_pkg::ST_NULL_ADDRESS;
                state      <= S_DONE;
              end else begin
                state <= S_FCHK;
              end
            end
          end
        end
        S_ASCAN: begin
          scan_row <= scan_row + 1'b1;
          chk_row  <= scan_row[bbpa_pkg::RA_W-1:0];
          chk_vld  <= issue_ok;
          if (hit) begin
            idx   <= {chk_row, hit_bit};
            state <= S_AMUL;
          end else if (!issue_ok) begin
            res.status <= bbpa_pkg::ST_EMPTY;
            state      <= S_DONE;
          end
        end
        S_AMUL: begin
          prod  <= bbpa_pkg::PROD_W'(idx) * bbpa_pkg::PROD_W'(block_size);
          state <= S_AADD;
        end
        S_AADD: begin
          res.status        <= bbpa_pkg::ST_OK;
          res.block_address <= base_address + 32'(prod);
          res.block_number  <= 8'(idx);
          state             <= S_DONE;
        end
        S_FCHK: begin
          if (out_of_pool) begin
            res.status <= bbpa_pkg::ST_OUT_OF_RANGE;
            state      <= S_DONE;
          end else begin
            state <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (div_done) begin
            idx   <= div_q;
            state <= S_FRD;
          end
        end
        S_FRD: begin
          state <= S_FWR;
        end
        S_FWR: begin
          res.status       <= bbpa_pkg::ST_OK;
          res.block_number <= 8'(idx);
          state            <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
      out_data  <= res;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_no_map_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_re && map_wr.en) |-> (ram_raddr != map_wr.addr))
    else $error("bitmap row read and written in the same cycle");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the done state");

  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_FDIV))
    else $error("divider finished while no free request waits on it");

  a_alloc_in_pool: assert property (@(posedge clk) disable iff (rst)
    (state == S_AMUL) |-> ({1'b0, idx} < n_use))
    else $error("allocated block lies outside the pool");

endmodule

`default_nettype wire

@@ rtl/core/bbpa_map_ram.sv @@
// bbpa_map_ram: free bitmap storage, one row of bits per word, registered read
// depends on bbpa_pkg
`default_nettype none

module bbpa_map_ram (
  input  wire                        clk,
  input  wire bbpa_pkg::map_wr_t     wr,
  input  wire                        re,
  input  wire  [bbpa_pkg::RA_W-1:0]  raddr,
  output logic [bbpa_pkg::ROW_W-1:0] rdata
);

  logic [bbpa_pkg::ROW_W-1:0] mem [bbpa_pkg::ROWS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bbpa_div.sv @@
// bbpa_div: restoring divider, one quotient bit per cycle, turns a pool offset into a block index
// depends on bbpa_pkg
`default_nettype none

module bbpa_div (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  input  wire  [31:0]                dividend,
  input  wire  [15:0]                divisor,
  output logic                       done,
  output logic [bbpa_pkg::IDX_W-1:0] quotient
);

  logic                        busy;
  logic [bbpa_pkg::STEP_W-1:0] step;
  logic [31:0]                 rem;
  logic [31:0]                 trial;
  logic                        fits;

  assign trial = {16'd0, divisor} << step;
  assign fits  = rem >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= bbpa_pkg::STEP_W'(bbpa_pkg::IDX_W - 1);
        rem      <= dividend;
        quotient <= '0;
      end else if (busy) begin
        if (fits) begin
          rem            <= rem - trial;
          quotient[step] <= 1'b1;
        end
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ dv/bitmap_block_pool_allocator_unit_tb.sv @@
// testbench for bitmap_block_pool_allocator_unit: directed table, then random pool traffic
// across several register settings, checked against a behavioral model of the free bitmap
// depends on bbpa_pkg and the allocator rtl
`timescale 1ns / 1ps

module bitmap_block_pool_allocator_unit_tb;

  localparam int LATENCY_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 150;
  localparam int PHASES         = 8;

  typedef struct {
    bit                             is_write;
    logic [bbpa_pkg::CFG_IDX_W-1:0] reg_index;
    logic [31:0]                    reg_value;
    bbpa_pkg::req_t                 request;
    bit                             typed;
    bbpa_pkg::rsp_t                 typed_result;
  } plan_row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [bbpa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bbpa_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  bbpa_pkg::req_t                  in_data = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  bbpa_pkg::rsp_t                  out_data;

  // model state
  logic [bbpa_pkg::MAX_BLOCKS-1:0] free_map;
  logic [31:0]                     pool_base;
  logic [15:0]                     pool_size;
  logic [8:0]                      pool_count;

  bbpa_pkg::rsp_t expected_results[$];
  bbpa_pkg::rsp_t oldest_expected;
  plan_row_t      directed_plan[$];
  int             mismatches = 0;
  int             tx_idle_pct = 0;
  int             rx_stall_pct = 0;
  bit             hold_request = 1'b0;
  int             hold_left = 0;
  int             quiet_cycles;

  bitmap_block_pool_allocator_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned blocks_in_use();
    return (pool_count > bbpa_pkg::MAX_BLOCKS) ? bbpa_pkg::MAX_BLOCKS : pool_count;
  endfunction

  function automatic bbpa_pkg::rsp_t pool_step(input bbpa_pkg::req_t r);
    bbpa_pkg::rsp_t res;
    int unsigned    n;
    int unsigned    idx;
    bit             found;
    logic [31:0]    offset;
    logic [63:0]    span;
    res.status        = bbpa_pkg::ST_OK;
    res.block_address = '0;
    res.block_number  = '0;
    n = blocks_in_use();
    if (r.kind == bbpa_pkg::KIND_ALLOC) begin
      if (r.request_length > pool_size) begin
        res.status = bbpa_pkg::ST_TOO_LARGE;
      end else begin
        found = 1'b0;
        for (int i = 0; i < n; i++) begin
          if (!found && free_map[i]) begin
            found = 1'b1;
            free_map[i] = 1'b0;
            res.block_address = pool_base + 32'(i) * 32'(pool_size);
            res.block_number  = 8'(i);
          end
        end
        if (!found) res.status = bbpa_pkg::ST_EMPTY;
      end
    end else if (r.free_address == '0) begin
      res.status = bbpa_pkg::ST_NULL_ADDRESS;
    end else if (pool_size == '0 || r.free_address < pool_base) begin
      res.status = bbpa_pkg::ST_OUT_OF_RANGE;
    end else begin
      offset = r.free_address - pool_base;
      span   = 64'(n) * 64'(pool_size);
      if (64'(offset) >= span) begin
        res.status = bbpa_pkg::ST_OUT_OF_RANGE;
      end else begin
        idx = offset / 32'(pool_size);
        free_map[idx] = 1'b1;
        res.block_number = 8'(idx);
      end
    end
    return res;
  endfunction

  function automatic bbpa_pkg::req_t random_request();
    bbpa_pkg::req_t r;
    int unsigned    n;
    int unsigned    roll;
    n = blocks_in_use();
    r.kind           = bbpa_pkg::KIND_FREE;
    r.request_length = 16'($urandom);
    r.free_address   = $urandom;
    roll = $urandom_range(99);
    if (roll < 50) begin
      r.kind = bbpa_pkg::KIND_ALLOC;
      if ($urandom_range(9) != 0) r.request_length = 16'($urandom_range(pool_size));
    end else if (roll < 85) begin
      if (n > 0 && pool_size != '0)
        r.free_address = pool_base + 32'($urandom_range(n - 1)) * 32'(pool_size)
                         + 32'($urandom_range(pool_size - 1));
    end else if (roll < 90) begin
      // last byte of the pool or the first one past it
      r.free_address = pool_base + 32'(n) * 32'(pool_size) - 32'($urandom_range(1));
    end else if (roll < 95) begin
      r.free_address = '0;
    end
    return r;
  endfunction

  function automatic plan_row_t row_req(input logic kind, input logic [15:0] len,
                                        input logic [31:0] addr);
    plan_row_t row;
    row.is_write     = 1'b0;
    row.reg_index    = '0;
    row.reg_value    = '0;
    row.request      = '{kind, len, addr};
    row.typed        = 1'b0;
    row.typed_result = '{bbpa_pkg::ST_OK, 32'd0, 8'd0};
    return row;
  endfunction

  function automatic plan_row_t row_typed(input logic kind, input logic [15:0] len,
                                          input logic [31:0] addr,
                                          input bbpa_pkg::status_t st,
                                          input logic [31:0] baddr, input logic [7:0] bnum);
    plan_row_t row;
    row = row_req(kind, len, addr);
    row.typed        = 1'b1;
    row.typed_result = '{st, baddr, bnum};
    return row;
  endfunction

  function automatic plan_row_t row_write(input logic [bbpa_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [31:0] val);
    plan_row_t row;
    row = row_req(bbpa_pkg::KIND_ALLOC, '0, '0);
    row.is_write  = 1'b1;
    row.reg_index = idx;
    row.reg_value = val;
    return row;
  endfunction

  task automatic send_request(input bbpa_pkg::req_t r, input bit typed,
                              input bbpa_pkg::rsp_t typed_result);
    bbpa_pkg::rsp_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = r;
    do @(posedge clk); while (!in_ready);
    predicted = pool_step(r);
    expected_results.push_back(typed ? typed_result : predicted);
    @(negedge clk);
  endtask

  task automatic settle_pool();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (LATENCY_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [bbpa_pkg::CFG_IDX_W-1:0] idx,
                                input logic [31:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      bbpa_pkg::REG_BASE_ADDRESS: pool_base  = val;
      bbpa_pkg::REG_BLOCK_SIZE:   pool_size  = val[15:0];
      bbpa_pkg::REG_BLOCK_COUNT:  pool_count = val[8:0];
      default: ;
    endcase
  endtask

  // receiver side
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request pending: status %0d address %h number %0d",
                 $time, out_data.status, out_data.block_address, out_data.block_number);
        mismatches++;
      end else begin
        oldest_expected = expected_results.pop_front();
        if (out_data.status !== oldest_expected.status) begin
          $display("%0t: status expected %0d actual %0d", $time, oldest_expected.status,
                   out_data.status);
          mismatches++;
        end
        if (out_data.block_address !== oldest_expected.block_address) begin
          $display("%0t: block_address expected %h actual %h", $time,
                   oldest_expected.block_address, out_data.block_address);
          mismatches++;
        end
        if (out_data.block_number !== oldest_expected.block_number) begin
          $display("%0t: block_number expected %0d actual %0d", $time,
                   oldest_expected.block_number, out_data.block_number);
          mismatches++;
        end
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("bitmap_block_pool_allocator_unit test failed");
    $finish;
  end

  initial begin
    logic [31:0] base_v;
    logic [15:0] size_v;
    logic [8:0]  count_v;

    free_map   = '1;
    pool_base  = bbpa_pkg::BASE_ADDRESS_RESET;
    pool_size  = bbpa_pkg::BLOCK_SIZE_RESET;
    pool_count = bbpa_pkg::BLOCK_COUNT_RESET;

    // reset settings: base 0x2000_0000, 64 byte blocks, 256 blocks
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_ALLOC, 16'd0, 32'h0, bbpa_pkg::ST_OK,
                                      32'h2000_0000, 8'd0));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_ALLOC, 16'd64, 32'hFFFF_FFFF,
                                      bbpa_pkg::ST_OK, 32'h2000_0040, 8'd1));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_ALLOC, 16'd65, 32'h0,
                                      bbpa_pkg::ST_TOO_LARGE, 32'h0, 8'd0));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_ALLOC, 16'hFFFF, 32'h0,
                                      bbpa_pkg::ST_TOO_LARGE, 32'h0, 8'd0));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_FREE, 16'd0, 32'h0,
                                      bbpa_pkg::ST_NULL_ADDRESS, 32'h0, 8'd0));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_FREE, 16'd0, 32'h1FFF_FFFF,
                                      bbpa_pkg::ST_OUT_OF_RANGE, 32'h0, 8'd0));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_FREE, 16'd0, 32'h2000_0041,
                                      bbpa_pkg::ST_OK, 32'h0, 8'd1));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_FREE, 16'd0, 32'h2000_0041,
                                      bbpa_pkg::ST_OK, 32'h0, 8'd1));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_FREE, 16'd0, 32'h2000_3FFF,
                                      bbpa_pkg::ST_OK, 32'h0, 8'd255));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_FREE, 16'd0, 32'h2000_4000,
                                      bbpa_pkg::ST_OUT_OF_RANGE, 32'h0, 8'd0));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_FREE, 16'hFFFF, 32'hFFFF_FFFF,
                                      bbpa_pkg::ST_OUT_OF_RANGE, 32'h0, 8'd0));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_FREE, 16'd0, 32'h2000_0000,
                                      bbpa_pkg::ST_OK, 32'h0, 8'd0));
    // empty pool
    directed_plan.push_back(row_write(bbpa_pkg::REG_BLOCK_COUNT, 32'd0));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_ALLOC, 16'd0, 32'h0,
                                      bbpa_pkg::ST_EMPTY, 32'h0, 8'd0));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_FREE, 16'd0, 32'h2000_0000,
                                      bbpa_pkg::ST_OUT_OF_RANGE, 32'h0, 8'd0));
    // zero block size
    directed_plan.push_back(row_write(bbpa_pkg::REG_BLOCK_COUNT, 32'd4));
    directed_plan.push_back(row_write(bbpa_pkg::REG_BLOCK_SIZE, 32'd0));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_ALLOC, 16'd0, 32'h0, bbpa_pkg::ST_OK,
                                      32'h2000_0000, 8'd0));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_ALLOC, 16'd0, 32'h0, bbpa_pkg::ST_OK,
                                      32'h2000_0000, 8'd1));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_ALLOC, 16'd1, 32'h0,
                                      bbpa_pkg::ST_TOO_LARGE, 32'h0, 8'd0));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_FREE, 16'd0, 32'h2000_0000,
                                      bbpa_pkg::ST_OUT_OF_RANGE, 32'h0, 8'd0));
    // pool reaching past the top of the address space
    directed_plan.push_back(row_write(bbpa_pkg::REG_BASE_ADDRESS, 32'hFFFF_FF00));
    directed_plan.push_back(row_write(bbpa_pkg::REG_BLOCK_SIZE, 32'd256));
    directed_plan.push_back(row_write(bbpa_pkg::REG_BLOCK_COUNT, 32'd3));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_ALLOC, 16'd256, 32'h0, bbpa_pkg::ST_OK,
                                      32'h0000_0100, 8'd2));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_FREE, 16'd0, 32'h0000_0100,
                                      bbpa_pkg::ST_OUT_OF_RANGE, 32'h0, 8'd0));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_FREE, 16'd0, 32'hFFFF_FFFF,
                                      bbpa_pkg::ST_OK, 32'h0, 8'd0));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_ALLOC, 16'd0, 32'h0, bbpa_pkg::ST_OK,
                                      32'hFFFF_FF00, 8'd0));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_ALLOC, 16'd0, 32'h0,
                                      bbpa_pkg::ST_EMPTY, 32'h0, 8'd0));
    // null check ahead of a zero base
    directed_plan.push_back(row_write(bbpa_pkg::REG_BASE_ADDRESS, 32'd0));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_FREE, 16'd0, 32'h0,
                                      bbpa_pkg::ST_NULL_ADDRESS, 32'h0, 8'd0));
    // count above capacity, largest blocks
    directed_plan.push_back(row_write(bbpa_pkg::REG_BASE_ADDRESS, 32'd1));
    directed_plan.push_back(row_write(bbpa_pkg::REG_BLOCK_SIZE, 32'hFFFF));
    directed_plan.push_back(row_write(bbpa_pkg::REG_BLOCK_COUNT, 32'h1FF));
    directed_plan.push_back(row_req(bbpa_pkg::KIND_ALLOC, 16'hFFFF, 32'h0));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_FREE, 16'd0, 32'h00FF_FF00,
                                      bbpa_pkg::ST_OK, 32'h0, 8'd255));
    directed_plan.push_back(row_typed(bbpa_pkg::KIND_FREE, 16'd0, 32'h00FF_FF01,
                                      bbpa_pkg::ST_OUT_OF_RANGE, 32'h0, 8'd0));

    repeat (5) @(negedge clk);
    rst = 1'b0;

    foreach (directed_plan[k]) begin
      if (directed_plan[k].is_write) begin
        settle_pool();
        write_register(directed_plan[k].reg_index, directed_plan[k].reg_value);
      end else begin
        send_request(directed_plan[k].request, directed_plan[k].typed,
                     directed_plan[k].typed_result);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          base_v  = bbpa_pkg::BASE_ADDRESS_RESET;
          size_v  = 16'd64;
          count_v = 9'd256;
        end
        1: begin base_v = 32'hFFFF_FFFF; size_v = 16'd1; count_v = 9'd256; end
        2: begin base_v = 32'd1; size_v = 16'hFFFF; count_v = 9'd8; end
        3: begin base_v = 32'h1234_5000; size_v = 16'd0; count_v = 9'd16; end
        4: begin base_v = $urandom; size_v = 16'($urandom_range(1, 4096)); count_v = 9'd1; end
        5: begin base_v = $urandom; size_v = 16'($urandom_range(1, 65535)); count_v = 9'h1FF; end
        6: begin
          base_v  = $urandom;
          size_v  = 16'($urandom_range(1, 4096));
          count_v = 9'($urandom_range(1, 256));
        end
        default: begin base_v = 32'h8000_0000; size_v = 16'd16; count_v = 9'd32; end
      endcase
      settle_pool();
      write_register(bbpa_pkg::REG_BASE_ADDRESS, base_v);
      write_register(bbpa_pkg::REG_BLOCK_SIZE, 32'(size_v));
      write_register(bbpa_pkg::REG_BLOCK_COUNT, 32'(count_v));
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 53; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 53; end
        default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
      endcase
      // long receiver hold-off so the block backs up into its input
      if (ph == PHASES - 1) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_request(random_request(), 1'b0, '{bbpa_pkg::ST_OK, 32'd0, 8'd0});
    end

    settle_pool();
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      mismatches += expected_results.size();
    end
    if (mismatches == 0) begin
      $display("bitmap_block_pool_allocator_unit test passed");
    end else begin
      $display("bitmap_block_pool_allocator_unit test failed");
    end
    $finish;
  end

endmodule
